FILE: hdl/bcld_pkg.sv
// ----------------------------------------------------------------------------
// bcld_pkg
// shared types, register map and event codes for the button click detector
// ----------------------------------------------------------------------------
package bcld_pkg;

    localparam int TIME_WIDTH_DEF = 32;
    localparam int APB_AW         = 5;
    localparam int APB_DW         = 32;
    localparam int CLICK_W        = 4;

    // register indexes
    localparam logic [2:0] REG_DEBOUNCE   = 3'd0;
    localparam logic [2:0] REG_CLICK_GAP  = 3'd1;
    localparam logic [2:0] REG_LONG_PRESS = 3'd2;
    localparam logic [2:0] REG_MAX_CLICKS = 3'd3;
    localparam logic [2:0] REG_LONG_EN    = 3'd4;
    localparam logic [2:0] REG_RELEASE_EN = 3'd5;

    // event codes
    localparam logic [1:0] EV_CLICK   = 2'd0;
    localparam logic [1:0] EV_LONG    = 2'd1;
    localparam logic [1:0] EV_RELEASE = 2'd2;

    // request codes
    localparam logic REQ_REPORT   = 1'b0;
    localparam logic REQ_EVALUATE = 1'b1;

    // reset values
    localparam logic [15:0]        DEBOUNCE_RST   = 16'd20;
    localparam logic [15:0]        CLICK_GAP_RST  = 16'd300;
    localparam logic [15:0]        LONG_PRESS_RST = 16'd1000;
    localparam logic [CLICK_W-1:0] MAX_CLICKS_RST = 4'd1;

    typedef struct packed {
        logic        req_type;
        logic        level;
        logic [31:0] now_ms;
    } in_word_t;

    typedef struct packed {
        logic [1:0]         event_kind;
        logic [CLICK_W-1:0] click_count;
        logic               last;
    } out_word_t;

    typedef struct packed {
        logic [15:0]        debounce_ms;
        logic [15:0]        click_gap_ms;
        logic [15:0]        long_press_ms;
        logic [CLICK_W-1:0] max_clicks;
        logic               long_press_enable;
        logic               release_event_enable;
    } cfg_t;

    typedef struct packed {
        logic               level_now;
        logic               level_seen;
        logic [CLICK_W-1:0] clicks_so_far;
        logic               long_held;
        logic               held_single_click;
    } flags_t;

endpackage

FILE: hdl/bcld_eval.sv
// ----------------------------------------------------------------------------
// bcld_eval
// single-pass next-state and event logic for one report or evaluate word
// ----------------------------------------------------------------------------
module bcld_eval #(
    parameter int TIME_WIDTH = bcld_pkg::TIME_WIDTH_DEF
) (
    input  bcld_pkg::cfg_t      cfg,
    input  bcld_pkg::in_word_t  in_word,
    input  bcld_pkg::flags_t    flags,
    input  logic [TIME_WIDTH-1:0] change_time,
    input  logic [TIME_WIDTH-1:0] press_time,
    output bcld_pkg::flags_t    flags_next,
    output logic [TIME_WIDTH-1:0] change_time_next,
    output logic [TIME_WIDTH-1:0] press_time_next,
    output bcld_pkg::out_word_t ev0,
    output bcld_pkg::out_word_t ev1,
    output logic [1:0]          ev_n
);
    import bcld_pkg::*;

    localparam int NCAND = 7;

    logic [TIME_WIDTH-1:0] now_t;
    logic [TIME_WIDTH-1:0] el_change;
    logic [TIME_WIDTH-1:0] el_press;
    logic [15:0]           thr;

    logic               cand_v [NCAND];
    logic [1:0]         cand_k [NCAND];
    logic [CLICK_W-1:0] cand_c [NCAND];

    assign now_t     = in_word.now_ms[TIME_WIDTH-1:0];
    assign el_change = now_t - change_time;
    assign el_press  = now_t - press_time;

    always_comb begin
        thr = cfg.long_press_ms;
        if ((cfg.max_clicks > 4'd1) && cfg.long_press_enable
                && (cfg.long_press_ms < cfg.click_gap_ms)) begin
            thr = cfg.click_gap_ms;
        end
    end

    // state update and candidate events in model order
    always_comb begin
        logic               oldv;
        logic               newv;
        logic [CLICK_W-1:0] clk;
        logic               hs;
        logic               lh;

        flags_next       = flags;
        change_time_next = change_time;
        press_time_next  = press_time;
        for (int i = 0; i < NCAND; i++) begin
            cand_v[i] = 1'b0;
            cand_k[i] = EV_CLICK;
            cand_c[i] = '0;
        end
        oldv = flags.level_seen;
        newv = flags.level_now;
        clk  = flags.clicks_so_far;
        hs   = flags.held_single_click;
        lh   = flags.long_held;

        if (in_word.req_type == REQ_REPORT) begin
            if (in_word.level != flags.level_now) begin
                flags_next.level_now = in_word.level;
                change_time_next     = now_t;
                if (in_word.level) begin
                    press_time_next = now_t;
                end
            end
        end else if ({{(TIME_WIDTH-16){1'b0}}, cfg.debounce_ms} <= el_change) begin
            // burst timeout
            if ((clk != '0)
                    && ({{(TIME_WIDTH-16){1'b0}}, cfg.click_gap_ms} < el_press)) begin
                cand_v[0] = !hs;
                cand_c[0] = clk;
                clk       = '0;
                if (!oldv && !newv) begin
                    cand_v[1] = hs;
                    cand_c[1] = CLICK_W'(1);
                    hs        = 1'b0;
                    cand_v[2] = cfg.release_event_enable;
                    cand_k[2] = EV_RELEASE;
                end
            end

            if (oldv && newv) begin
                if (cfg.long_press_enable && !lh
                        && ({{(TIME_WIDTH-16){1'b0}}, thr} < el_press)) begin
                    cand_v[3] = 1'b1;
                    cand_k[3] = EV_LONG;
                    lh        = 1'b1;
                    hs        = 1'b0;
                end
            end else if (oldv && !newv) begin
                if (clk == '0) begin
                    cand_v[4] = hs;
                    cand_c[4] = CLICK_W'(1);
                    hs        = 1'b0;
                    cand_v[5] = cfg.release_event_enable;
                    cand_k[5] = EV_RELEASE;
                end
                lh = 1'b0;
            end else if (!oldv && newv) begin
                if (cfg.max_clicks > clk) begin
                    clk = clk + CLICK_W'(1);
                    hs  = (cfg.max_clicks == CLICK_W'(1)) && (clk == CLICK_W'(1))
                          && cfg.long_press_enable;
                    if (cfg.max_clicks <= clk) begin
                        cand_v[6] = !hs;
                        cand_c[6] = clk;
                        clk       = '0;
                    end
                end
            end

            flags_next.level_seen        = newv;
            flags_next.clicks_so_far     = clk;
            flags_next.held_single_click = hs;
            flags_next.long_held         = lh;
        end
    end

    // keep the first two events
    always_comb begin
        logic [1:0] n;

        n   = 2'd0;
        ev0 = '0;
        ev1 = '0;
        for (int i = 0; i < NCAND; i++) begin
            if (cand_v[i]) begin
                if (n == 2'd0) begin
                    ev0.event_kind  = cand_k[i];
                    ev0.click_count = cand_c[i];
                end else if (n == 2'd1) begin
                    ev1.event_kind  = cand_k[i];
                    ev1.click_count = cand_c[i];
                end
                if (n != 2'd2) begin
                    n = n + 2'd1;
                end
            end
        end
        ev0.last = (n == 2'd1);
        ev1.last = 1'b1;
        ev_n     = n;
    end

endmodule

FILE: hdl/button_click_longpress_detector_unit.sv
// ----------------------------------------------------------------------------
// button_click_longpress_detector_unit
// push button debounce, multi-click bursts, long press and release events
// ----------------------------------------------------------------------------
// Each input word is either a level report or an evaluate tick carrying the
// current millisecond time. A word's state update is done in the cycle it is
// taken; its zero, one or two events go into a two-entry result queue. A new
// word is accepted whenever the queue is empty or its last entry is being taken
// in that cycle, so while m_ready is high words with at most one event run at
// one per cycle; a word with two events blocks new words until one result pops.
// Users must write settings through the APB port only while idle; not enforced.
module button_click_longpress_detector_unit #(
    parameter int TIME_WIDTH = bcld_pkg::TIME_WIDTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bcld_pkg::APB_AW-1:0]   paddr,
    input  logic [bcld_pkg::APB_DW-1:0]   pwdata,
    output logic [bcld_pkg::APB_DW-1:0]   prdata,
    output logic                          pready,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  bcld_pkg::in_word_t            s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output bcld_pkg::out_word_t           m_data
);
    import bcld_pkg::*;

    cfg_t                  cfg_reg;
    flags_t                flags_reg, flags_next;
    logic [TIME_WIDTH-1:0] change_time_reg, change_time_next;
    logic [TIME_WIDTH-1:0] press_time_reg, press_time_next;
    out_word_t             q0_reg, q1_reg;
    logic [1:0]            count_reg;
    out_word_t             ev0, ev1;
    logic [1:0]            ev_n;
    logic [2:0]            reg_idx;
    logic                  accept;
    logic                  pop;

    assign pready  = 1'b1;
    assign reg_idx = paddr[APB_AW-1:2];

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.debounce_ms          <= DEBOUNCE_RST;
            cfg_reg.click_gap_ms         <= CLICK_GAP_RST;
            cfg_reg.long_press_ms        <= LONG_PRESS_RST;
            cfg_reg.max_clicks           <= MAX_CLICKS_RST;
            cfg_reg.long_press_enable    <= 1'b1;
            cfg_reg.release_event_enable <= 1'b0;
        end else if (psel && penable && pwrite && pready) begin
            unique case (reg_idx)
                REG_DEBOUNCE:   cfg_reg.debounce_ms          <= pwdata[15:0];
                REG_CLICK_GAP:  cfg_reg.click_gap_ms         <= pwdata[15:0];
                REG_LONG_PRESS: cfg_reg.long_press_ms        <= pwdata[15:0];
                REG_MAX_CLICKS: cfg_reg.max_clicks           <= pwdata[CLICK_W-1:0];
                REG_LONG_EN:    cfg_reg.long_press_enable    <= pwdata[0];
                REG_RELEASE_EN: cfg_reg.release_event_enable <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (reg_idx)
            REG_DEBOUNCE:   prdata = {16'd0, cfg_reg.debounce_ms};
            REG_CLICK_GAP:  prdata = {16'd0, cfg_reg.click_gap_ms};
            REG_LONG_PRESS: prdata = {16'd0, cfg_reg.long_press_ms};
            REG_MAX_CLICKS: prdata = {{(APB_DW-CLICK_W){1'b0}}, cfg_reg.max_clicks};
            REG_LONG_EN:    prdata = {{(APB_DW-1){1'b0}}, cfg_reg.long_press_enable};
            REG_RELEASE_EN: prdata = {{(APB_DW-1){1'b0}}, cfg_reg.release_event_enable};
            default:        prdata = '0;
        endcase
    end

    bcld_eval #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_eval (
        .cfg              (cfg_reg),
        .in_word          (s_data),
        .flags            (flags_reg),
        .change_time      (change_time_reg),
        .press_time       (press_time_reg),
        .flags_next       (flags_next),
        .change_time_next (change_time_next),
        .press_time_next  (press_time_next),
        .ev0              (ev0),
        .ev1              (ev1),
        .ev_n             (ev_n)
    );

    assign m_valid = (count_reg != 2'd0);
    assign m_data  = q0_reg;
    assign pop     = m_valid && m_ready;
    assign s_ready = (count_reg == 2'd0) || ((count_reg == 2'd1) && m_ready);
    assign accept  = s_valid && s_ready;

    // detector state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flags_reg       <= '0;
            change_time_reg <= '0;
            press_time_reg  <= '0;
        end else if (accept) begin
            flags_reg       <= flags_next;
            change_time_reg <= change_time_next;
            press_time_reg  <= press_time_next;
        end
    end

    // result queue
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= 2'd0;
        end else if (accept) begin
            count_reg <= ev_n;
        end else if (pop) begin
            count_reg <= count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            q0_reg <= ev0;
            q1_reg <= ev1;
        end else if (pop) begin
            q0_reg <= q1_reg;
        end
    end

    a_event_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && (ev_n != 2'd0)) |=> m_valid)
        else $error("accepted word with events gave no result");

    a_partner_queued: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_data.last) |-> (count_reg == 2'd2))
        else $error("non-final result without its partner");

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg != 2'd3)
        else $error("result queue overfilled");

    a_kind_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.event_kind != 2'd3))
        else $error("undefined event kind on output");

endmodule
